/* rtl/core/buffer_pool_allocator_with_quota_macros.svh */
// Assertion macros for the buffer pool allocator.
// Used by the top level only; no other dependencies.
`ifndef BUFFER_POOL_ALLOCATOR_WITH_QUOTA_MACROS_SVH
`define BUFFER_POOL_ALLOCATOR_WITH_QUOTA_MACROS_SVH

// Hold cond at every edge out of reset.
`define BPAQ_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Require cons in the same cycle as ante.
`define BPAQ_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Require cons in the cycle after ante.
`define BPAQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/bpaq_pkg.sv */
// Shared types, codes and constants of the buffer pool allocator.
// No dependencies; compiled first.
package bpaq_pkg;

  localparam int BLOCKS      = 64;
  localparam int IW          = $clog2(BLOCKS);
  localparam int RESERVE_DIV = 5;

  typedef logic          opcode_t;
  typedef logic [1:0]    class_t;
  typedef logic [2:0]    status_t;
  typedef logic [IW-1:0] idx_t;
  typedef logic [6:0]    cnt_t;
  typedef logic [6:0]    ridx_t;
  typedef logic [3:0]    cfg_idx_t;
  typedef logic [6:0]    cfg_data_t;

  localparam opcode_t OP_ALLOC  = 1'b0;
  localparam opcode_t OP_RETURN = 1'b1;

  localparam class_t CLS_RECEIVE = 2'd0;
  localparam class_t CLS_DATA    = 2'd1;
  localparam class_t CLS_CONTROL = 2'd2;

  localparam status_t ST_GRANTED      = 3'd0;
  localparam status_t ST_CAP          = 3'd1;
  localparam status_t ST_WAIT         = 3'd2;
  localparam status_t ST_EMPTY        = 3'd3;
  localparam status_t ST_RETURNED     = 3'd4;
  localparam status_t ST_NULL         = 3'd5;
  localparam status_t ST_BAD_INDEX    = 3'd6;
  localparam status_t ST_ALREADY_FREE = 3'd7;

  localparam cfg_idx_t REG_MAX_OTHER    = 4'd0;
  localparam cfg_idx_t REG_DATA_RESERVE = 4'd1;

  localparam cnt_t CREDIT_MAX        = 7'd127;
  localparam cnt_t RST_DATA_RESERVE  = cnt_t'(BLOCKS / RESERVE_DIV);
  localparam cnt_t RST_MAX_OTHER     = cnt_t'(BLOCKS - BLOCKS / RESERVE_DIV);

  // Free stack command: pop the head for a grant, push a returned block.
  typedef struct packed {
    logic push;
    logic pop;
    idx_t push_idx;
  } stack_cmd_t;

endpackage

/* rtl/core/bpaq_if.sv */
// Valid/ready channel interfaces: request, result and configuration write.
// Depends on bpaq_pkg.
interface bpaq_in_if import bpaq_pkg::*; ();
  logic    valid;
  logic    ready;
  opcode_t opcode;
  class_t  request_class;
  logic    no_block;
  ridx_t   return_index;

  modport source (output valid, opcode, request_class, no_block, return_index,
                  input ready);
  modport sink   (input valid, opcode, request_class, no_block, return_index,
                  output ready);
endinterface

interface bpaq_out_if import bpaq_pkg::*; ();
  logic    valid;
  logic    ready;
  status_t status;
  idx_t    granted_index;
  cnt_t    blocks_in_use;
  cnt_t    other_in_use;

  modport source (output valid, status, granted_index, blocks_in_use, other_in_use,
                  input ready);
  modport sink   (input valid, status, granted_index, blocks_in_use, other_in_use,
                  output ready);
endinterface

interface bpaq_cfg_if import bpaq_pkg::*; ();
  logic      valid;
  logic      ready;
  cfg_idx_t  index;
  cfg_data_t data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/core/bpaq_free_stack.sv */
// LIFO free list of block indexes: head and next entry in registers, rest in memory.
// Depends on bpaq_pkg.
module bpaq_free_stack import bpaq_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  stack_cmd_t cmd,
  input  cnt_t       depth,
  output idx_t       top
);

  idx_t top_r;
  idx_t below_r;
  logic below_mem_r;
  idx_t mem_q_r;
  cnt_t lwm_r;
  idx_t mem [BLOCKS];

  idx_t below;
  idx_t wr_pos;
  idx_t rd_pos;
  cnt_t d_m1;
  cnt_t d_m2;

  assign below  = below_mem_r ? mem_q_r : below_r;
  assign d_m1   = depth - cnt_t'(1);
  assign d_m2   = depth - cnt_t'(2);
  assign wr_pos = d_m1[IW-1:0];
  assign rd_pos = idx_t'(depth - cnt_t'(3));
  assign top    = top_r;

  // Old head sinks one slot on a push; on a pop fetch the slot under the new head.
  always_ff @(posedge clk) begin
    if (cmd.push && depth != '0) begin
      mem[wr_pos] <= top_r;
    end
    if (cmd.pop) begin
      mem_q_r <= mem[rd_pos];
    end
  end

  // Slots below the low-water mark were never rewritten and still hold
  // their reset content, BLOCKS-1 minus the slot number.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_r       <= '0;
      below_r     <= idx_t'(1);
      below_mem_r <= 1'b0;
      lwm_r       <= cnt_t'(BLOCKS);
    end else if (cmd.push) begin
      top_r       <= cmd.push_idx;
      below_r     <= top_r;
      below_mem_r <= 1'b0;
    end else if (cmd.pop) begin
      top_r <= below;
      if (d_m2 < lwm_r) begin
        below_r     <= idx_t'(BLOCKS - 1) - rd_pos;
        below_mem_r <= 1'b0;
      end else begin
        below_mem_r <= 1'b1;
      end
      if (d_m1 < lwm_r) begin
        lwm_r <= d_m1;
      end
    end
  end

endmodule

/* rtl/core/buffer_pool_allocator_with_quota.sv */
// Path: an accepted request word is held in the input register; its result word is
// registered in the result register when the input register advances.
// Throughput: one request word per cycle; the input register advances whenever the
// result register is empty or being taken, so only a stalled result slows intake.
// Reset: synchronous, active low; counters, free marks and the free stack head clear
// at once, stack memory needs no clearing pass (a low-water mark covers reset content).
`include "buffer_pool_allocator_with_quota_macros.svh"

module buffer_pool_allocator_with_quota import bpaq_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  bpaq_in_if.sink    in_ch,
  bpaq_out_if.source out_ch,
  bpaq_cfg_if.sink   cfg_ch
);

  // Configuration and pool bookkeeping.
  cnt_t              max_other_r;
  cnt_t              credit_r;
  cnt_t              in_use_r;
  cnt_t              other_cnt_r;
  logic [BLOCKS-1:0] is_free_r;

  cnt_t              credit_nxt;
  cnt_t              in_use_nxt;
  cnt_t              other_cnt_nxt;
  logic [BLOCKS-1:0] is_free_nxt;

  // Class of each held block; undefined until a grant writes it.
  class_t class_mem [BLOCKS];

  // Input register.
  logic    s1_v_r;
  opcode_t s1_op_r;
  class_t  s1_cls_r;
  logic    s1_nob_r;
  ridx_t   s1_ridx_r;
  class_t  s1_bcls_r;

  // Result register.
  logic    out_v_r;
  status_t out_status_r;
  idx_t    out_gidx_r;
  cnt_t    out_used_r;
  cnt_t    out_other_r;

  logic       in_acc;
  logic       adv;
  logic       grant;
  logic       ret;
  logic       do_grant;
  logic       do_ret;
  logic       other_req;
  logic       other_blk;
  status_t    status_nxt;
  idx_t       top_idx;
  idx_t       ridx_blk;
  idx_t       in_blk;
  cnt_t       depth;
  cnt_t       used_dec;
  stack_cmd_t stack_cmd;

  // Handshake: advance the input register into the result register when that
  // slot is empty or drains this cycle.
  assign adv          = s1_v_r && (!out_v_r || out_ch.ready);
  assign in_ch.ready  = !s1_v_r || adv;
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  assign out_ch.valid         = out_v_r;
  assign out_ch.status        = out_status_r;
  assign out_ch.granted_index = out_gidx_r;
  assign out_ch.blocks_in_use = out_used_r;
  assign out_ch.other_in_use  = out_other_r;

  assign depth     = cnt_t'(BLOCKS) - in_use_r;
  assign used_dec  = in_use_r - cnt_t'(1);
  assign ridx_blk  = s1_ridx_r[IW-1:0];
  assign in_blk    = in_ch.return_index[IW-1:0];
  assign other_req = (s1_cls_r == CLS_RECEIVE) || (s1_cls_r == CLS_CONTROL);
  assign other_blk = (s1_bcls_r == CLS_RECEIVE) || (s1_bcls_r == CLS_CONTROL);
  assign do_grant  = adv && grant;
  assign do_ret    = adv && ret;

  // Decide the request: quota or credit first, then an empty pool.
  // A return tests the null reference, then the range, then the free mark.
  always_comb begin
    grant      = 1'b0;
    ret        = 1'b0;
    status_nxt = ST_EMPTY;
    if (s1_op_r == OP_ALLOC) begin
      if (other_req && other_cnt_r >= max_other_r) begin
        status_nxt = ST_CAP;
      end else if (s1_cls_r == CLS_DATA && credit_r == '0) begin
        status_nxt = ST_WAIT;
      end else if (in_use_r >= cnt_t'(BLOCKS)) begin
        status_nxt = ST_EMPTY;
      end else begin
        status_nxt = ST_GRANTED;
        grant      = 1'b1;
      end
    end else begin
      if (s1_nob_r) begin
        status_nxt = ST_NULL;
      end else if (s1_ridx_r >= ridx_t'(BLOCKS)) begin
        status_nxt = ST_BAD_INDEX;
      end else if (is_free_r[ridx_blk]) begin
        status_nxt = ST_ALREADY_FREE;
      end else begin
        status_nxt = ST_RETURNED;
        ret        = 1'b1;
      end
    end
  end

  // Bookkeeping: a grant charges the quota or the credit of its class, a
  // return refunds the class recorded at grant time. The unassigned class
  // touches neither.
  always_comb begin
    in_use_nxt    = in_use_r;
    other_cnt_nxt = other_cnt_r;
    credit_nxt    = credit_r;
    is_free_nxt   = is_free_r;
    if (grant) begin
      in_use_nxt           = in_use_r + cnt_t'(1);
      is_free_nxt[top_idx] = 1'b0;
      if (other_req) begin
        other_cnt_nxt = other_cnt_r + cnt_t'(1);
      end else if (s1_cls_r == CLS_DATA) begin
        credit_nxt = credit_r - cnt_t'(1);
      end
    end
    if (ret) begin
      is_free_nxt[ridx_blk] = 1'b1;
      if (in_use_r != '0) begin
        in_use_nxt = in_use_r - cnt_t'(1);
      end
      if (other_blk) begin
        if (other_cnt_r != '0) begin
          other_cnt_nxt = other_cnt_r - cnt_t'(1);
        end
      end else if (s1_bcls_r == CLS_DATA) begin
        // Saturate: a reload can leave the credit near the top.
        if (credit_r != CREDIT_MAX) begin
          credit_nxt = credit_r + cnt_t'(1);
        end
      end
    end
  end

  assign stack_cmd.push     = do_ret;
  assign stack_cmd.pop      = do_grant;
  assign stack_cmd.push_idx = ridx_blk;

  bpaq_free_stack u_stack (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (stack_cmd),
    .depth (depth),
    .top   (top_idx)
  );

  // Class memory: write on grant, read the returned block at accept. Forward
  // the class being written when the incoming word returns that same block.
  always_ff @(posedge clk) begin
    if (do_grant) begin
      class_mem[top_idx] <= s1_cls_r;
    end
    if (in_acc) begin
      if (do_grant && top_idx == in_blk) begin
        s1_bcls_r <= s1_cls_r;
      end else begin
        s1_bcls_r <= class_mem[in_blk];
      end
    end
  end

  // Input register payload.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_op_r   <= in_ch.opcode;
      s1_cls_r  <= in_ch.request_class;
      s1_nob_r  <= in_ch.no_block;
      s1_ridx_r <= in_ch.return_index;
    end
  end

  // Result register payload.
  always_ff @(posedge clk) begin
    if (adv) begin
      out_status_r <= status_nxt;
      out_gidx_r   <= grant ? top_idx : '0;
      out_used_r   <= in_use_nxt;
      out_other_r  <= other_cnt_nxt;
    end
  end

  // Valid flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_v_r <= 1'b1;
      end else if (adv) begin
        s1_v_r <= 1'b0;
      end
      if (adv) begin
        out_v_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  // Counters, free marks and registers. Writes to the reserve register reload the
  // credit; the user must send them only while the block is idle, it does not check.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_other_r <= RST_MAX_OTHER;
      credit_r    <= RST_DATA_RESERVE;
      in_use_r    <= '0;
      other_cnt_r <= '0;
      is_free_r   <= '1;
    end else begin
      if (adv) begin
        in_use_r    <= in_use_nxt;
        other_cnt_r <= other_cnt_nxt;
        is_free_r   <= is_free_nxt;
        credit_r    <= credit_nxt;
      end
      if (cfg_ch.valid) begin
        case (cfg_ch.index)
          REG_MAX_OTHER:    max_other_r <= cfg_ch.data;
          REG_DATA_RESERVE: credit_r    <= cfg_ch.data;
          default:          ;
        endcase
      end
    end
  end

  // Receive and control blocks are a subset of the blocks in use.
  `BPAQ_ASSERT_ALWAYS(a_other_le_used, clk, rst_n, other_cnt_r <= in_use_r, "other > in use")
  // The stack head must be a free block whenever it is granted.
  `BPAQ_ASSERT_IMPL(a_grant_free, clk, rst_n, do_grant, is_free_r[top_idx], "grant not free")
  // A good return drops the in-use count by one.
  `BPAQ_ASSERT_NEXT(a_ret_count, clk, rst_n, do_ret, in_use_r == $past(used_dec), "bad release")

endmodule

/* dv/testbench.sv */
// Self-checking testbench for buffer_pool_allocator_with_quota: drives request words and
// register writes, predicts every result word and compares it field by field.
// Depends on bpaq_pkg, the bpaq channel interfaces and the allocator RTL.
module testbench;
  import bpaq_pkg::*;

  // The fourth class code is legal on the wire but belongs to no quota or credit.
  localparam class_t   CLS_UNASSIGNED = 2'd3;
  // No register lives at this index; a write to it must change nothing.
  localparam cfg_idx_t REG_UNUSED     = 4'd15;

  localparam int RANDOM_WORDS = 1250;
  localparam int N_STEPS      = 25;
  // Cycles without any handshake before the run is declared hung.
  localparam int STALL_LIMIT  = 4000;

  typedef struct packed {
    opcode_t op;
    class_t  cls;
    logic    no_block;
    ridx_t   ridx;
  } req_t;

  typedef struct packed {
    status_t status;
    idx_t    granted;
    cnt_t    in_use;
    cnt_t    other;
  } res_t;

  typedef enum logic {ROW_WORD, ROW_CFG} row_kind_e;

  // One row of the directed table: a request word (with a typed result where fixed
  // is set) or a register write.
  typedef struct packed {
    row_kind_e kind;
    opcode_t   op;
    class_t    cls;
    logic      no_block;
    ridx_t     ridx;
    logic      fixed;
    status_t   status;
    idx_t      granted;
    cnt_t      in_use;
    cnt_t      other;
    cfg_idx_t  reg_idx;
    cfg_data_t reg_val;
  } step_t;

  // Directed opening. The first rows follow the pool from reset by hand: grants come
  // off the head in order 0, 1, 2, 3, then every return check is hit (null block
  // first even on a held block, both bad index extremes, a block that is still free).
  // Later rows depend on the LIFO order and are left to the predictor. The tail closes
  // both quotas and pokes an unmapped register index.
  localparam step_t STEPS [N_STEPS] = '{
    '{ROW_WORD, OP_ALLOC,  CLS_RECEIVE,    0,   0, 1, ST_GRANTED,      0, 1, 1, '0, 0},
    '{ROW_WORD, OP_ALLOC,  CLS_DATA,       0,   0, 1, ST_GRANTED,      1, 2, 1, '0, 0},
    '{ROW_WORD, OP_ALLOC,  CLS_CONTROL,    0,   0, 1, ST_GRANTED,      2, 3, 2, '0, 0},
    '{ROW_WORD, OP_ALLOC,  CLS_UNASSIGNED, 0,   0, 1, ST_GRANTED,      3, 4, 2, '0, 0},
    '{ROW_WORD, OP_RETURN, CLS_RECEIVE,    1,   0, 1, ST_NULL,         0, 4, 2, '0, 0},
    '{ROW_WORD, OP_RETURN, CLS_RECEIVE,    0, 127, 1, ST_BAD_INDEX,    0, 4, 2, '0, 0},
    '{ROW_WORD, OP_RETURN, CLS_DATA,       0,  64, 1, ST_BAD_INDEX,    0, 4, 2, '0, 0},
    '{ROW_WORD, OP_RETURN, CLS_CONTROL,    0,  63, 1, ST_ALREADY_FREE, 0, 4, 2, '0, 0},
    '{ROW_WORD, OP_RETURN, CLS_RECEIVE,    0,   1, 1, ST_RETURNED,     0, 3, 2, '0, 0},
    '{ROW_WORD, OP_RETURN, CLS_RECEIVE,    0,   1, 1, ST_ALREADY_FREE, 0, 3, 2, '0, 0},
    '{ROW_WORD, OP_ALLOC,  CLS_DATA,       1, 127, 0, ST_GRANTED,      0, 0, 0, '0, 0},
    '{ROW_WORD, OP_RETURN, CLS_RECEIVE,    0,   3, 0, ST_GRANTED,      0, 0, 0, '0, 0},
    '{ROW_WORD, OP_RETURN, CLS_RECEIVE,    0,   0, 0, ST_GRANTED,      0, 0, 0, '0, 0},
    '{ROW_WORD, OP_RETURN, CLS_RECEIVE,    0,   2, 0, ST_GRANTED,      0, 0, 0, '0, 0},
    '{ROW_WORD, OP_ALLOC,  CLS_RECEIVE,    1, 127, 0, ST_GRANTED,      0, 0, 0, '0, 0},
    '{ROW_WORD, OP_RETURN, CLS_UNASSIGNED, 0,   2, 0, ST_GRANTED,      0, 0, 0, '0, 0},
    '{ROW_CFG,  OP_ALLOC,  CLS_RECEIVE,    0,   0, 0, ST_GRANTED,      0, 0, 0,
      REG_MAX_OTHER, 0},
    '{ROW_CFG,  OP_ALLOC,  CLS_RECEIVE,    0,   0, 0, ST_GRANTED,      0, 0, 0,
      REG_DATA_RESERVE, 0},
    '{ROW_CFG,  OP_ALLOC,  CLS_RECEIVE,    0,   0, 0, ST_GRANTED,      0, 0, 0,
      REG_UNUSED, 127},
    '{ROW_WORD, OP_ALLOC,  CLS_RECEIVE,    0,   0, 1, ST_CAP,          0, 1, 0, '0, 0},
    '{ROW_WORD, OP_ALLOC,  CLS_DATA,       0,   0, 1, ST_WAIT,         0, 1, 0, '0, 0},
    '{ROW_WORD, OP_ALLOC,  CLS_CONTROL,    0,   0, 1, ST_CAP,          0, 1, 0, '0, 0},
    '{ROW_WORD, OP_ALLOC,  CLS_UNASSIGNED, 0,   0, 0, ST_GRANTED,      0, 0, 0, '0, 0},
    '{ROW_WORD, OP_RETURN, CLS_RECEIVE,    0,   1, 0, ST_GRANTED,      0, 0, 0, '0, 0},
    '{ROW_WORD, OP_ALLOC,  CLS_DATA,       0,   0, 0, ST_GRANTED,      0, 0, 0, '0, 0}
  };

  logic clk;
  logic rst_n;

  bpaq_in_if  in_ch  ();
  bpaq_out_if out_ch ();
  bpaq_cfg_if cfg_ch ();

  buffer_pool_allocator_with_quota uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Shadow of the pool: free list links, free marks, owning class of each block,
  // the two counters, the data credit and the cap on receive plus control blocks.
  int     pool_head;
  int     pool_link  [BLOCKS];
  bit     pool_free  [BLOCKS];
  class_t pool_owner [BLOCKS];
  int     held_total;
  int     held_other;
  int     credit;
  int     cap_other;

  // Results still owed by the block, oldest first.
  res_t pending_results [$];

  // Typed result for the word now on the request channel, when the table has one.
  bit   word_fixed;
  res_t word_want;

  int words_sent;
  int results_seen;
  int cfg_writes;
  int handshakes;
  int faults;
  int st_seen [8];
  int words_goal;
  int tx_idle_pct = 25;
  int rx_idle_pct = 72;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic bit other_class(class_t c);
    return c == CLS_RECEIVE || c == CLS_CONTROL;
  endfunction

  // Advance the shadow pool by one request word and return the result it owes.
  function automatic res_t pool_outcome(req_t r);
    res_t o;
    int   b;
    o = '0;
    if (r.op == OP_ALLOC) begin
      // Quota or credit first, then the empty pool: no credit is spent on an empty pool.
      if (other_class(r.cls) && held_other >= cap_other) begin
        o.status = ST_CAP;
      end else if (r.cls == CLS_DATA && credit == 0) begin
        o.status = ST_WAIT;
      end else if (held_total >= BLOCKS) begin
        o.status = ST_EMPTY;
      end else begin
        b = pool_head;
        pool_head = pool_link[b];
        pool_free[b] = 1'b0;
        pool_owner[b] = r.cls;
        held_total++;
        if (other_class(r.cls)) begin
          held_other++;
        end else if (r.cls == CLS_DATA) begin
          credit--;
        end
        o.status = ST_GRANTED;
        o.granted = idx_t'(b);
      end
    end else if (r.no_block) begin
      o.status = ST_NULL;
    end else if (int'(r.ridx) >= BLOCKS) begin
      o.status = ST_BAD_INDEX;
    end else if (pool_free[r.ridx]) begin
      o.status = ST_ALREADY_FREE;
    end else begin
      // The class on the word is ignored; the owner recorded at grant time decides.
      b = int'(r.ridx);
      if (held_total > 0) held_total--;
      pool_free[b] = 1'b1;
      pool_link[b] = pool_head;
      pool_head = b;
      if (other_class(pool_owner[b])) begin
        if (held_other > 0) held_other--;
      end else if (pool_owner[b] == CLS_DATA && credit < int'(CREDIT_MAX)) begin
        credit++;
      end
      o.status = ST_RETURNED;
    end
    o.in_use = cnt_t'(held_total);
    o.other = cnt_t'(held_other);
    return o;
  endfunction

  // Observe all three channels at the rising edge. Results are checked before the
  // request of the same edge is predicted, so a result can never match a word that
  // entered in the same cycle.
  always @(posedge clk) begin : observe
    res_t want;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        handshakes++;
        if (pending_results.size() == 0) begin
          $error("result word with no request pending: status %0d", out_ch.status);
          faults++;
        end else begin
          want = pending_results.pop_front();
          results_seen++;
          st_seen[out_ch.status]++;
          if (out_ch.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_ch.status);
            faults++;
          end
          if (out_ch.granted_index !== want.granted) begin
            $error("granted_index: expected %0d, got %0d", want.granted,
                   out_ch.granted_index);
            faults++;
          end
          if (out_ch.blocks_in_use !== want.in_use) begin
            $error("blocks_in_use: expected %0d, got %0d", want.in_use,
                   out_ch.blocks_in_use);
            faults++;
          end
          if (out_ch.other_in_use !== want.other) begin
            $error("other_in_use: expected %0d, got %0d", want.other,
                   out_ch.other_in_use);
            faults++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        handshakes++;
        words_sent++;
        // Always run the predictor so its state tracks the block, even on typed rows.
        want = pool_outcome(req_t'{in_ch.opcode, in_ch.request_class, in_ch.no_block,
                                   in_ch.return_index});
        if (word_fixed) want = word_want;
        pending_results.push_back(want);
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        handshakes++;
        cfg_writes++;
        // A reserve write reloads the credit outright, whatever is held.
        if (cfg_ch.index == REG_MAX_OTHER) begin
          cap_other = int'(cfg_ch.data);
        end else if (cfg_ch.index == REG_DATA_RESERVE) begin
          credit = int'(cfg_ch.data);
        end
      end
    end
  end

  // Result side backpressure; the idle share follows the phase of the run.
  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // Count cycles with no handshake on any channel; sampled at the falling edge so
  // it never races the observer.
  initial begin : watchdog
    int quiet;
    int last;
    quiet = 0;
    last = 0;
    @(posedge rst_n);
    while (quiet < STALL_LIMIT) begin
      @(negedge clk);
      if (handshakes != last) begin
        last = handshakes;
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("no handshake for %0d cycles, giving up", STALL_LIMIT);
    $display("Regression FAIL");
    $finish;
  end

  // Present one request word at a falling edge and hold it until taken.
  task automatic send_word(req_t r, bit fixed, res_t want);
    int gap;
    gap = 0;
    // Split the run in thirds: sender light and receiver heavy idling, then the
    // reverse, then full rate on both sides.
    if (words_sent < words_goal / 3) begin
      tx_idle_pct = 25;
      rx_idle_pct = 72;
    end else if (words_sent < 2 * words_goal / 3) begin
      tx_idle_pct = 72;
      rx_idle_pct = 25;
    end else begin
      tx_idle_pct = 0;
      rx_idle_pct = 0;
    end
    while ($urandom_range(99) < tx_idle_pct && gap < 64) gap++;
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    word_fixed = fixed;
    word_want = want;
    in_ch.valid <= 1'b1;
    in_ch.opcode <= r.op;
    in_ch.request_class <= r.cls;
    in_ch.no_block <= r.no_block;
    in_ch.return_index <= r.ridx;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // Drop valid and hold until every owed result has come back.
  task automatic quiesce();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  task automatic cfg_write(cfg_idx_t idx, cfg_data_t val);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic class_t rand_class();
    case ($urandom_range(9))
      0, 1, 2: return CLS_RECEIVE;
      3, 4, 5: return CLS_DATA;
      6, 7, 8: return CLS_CONTROL;
      default: return CLS_UNASSIGNED;
    endcase
  endfunction

  // Pick a random block that is held (held = 1) or free (held = 0); -1 if none.
  function automatic int pick_block(bit held);
    int hits;
    int k;
    hits = 0;
    foreach (pool_free[i]) if (pool_free[i] != held) hits++;
    if (hits == 0) return -1;
    k = $urandom_range(hits - 1);
    foreach (pool_free[i]) begin
      if (pool_free[i] != held) begin
        if (k == 0) return i;
        k--;
      end
    end
    return -1;
  endfunction

  function automatic cfg_data_t pick_setting(cfg_data_t home);
    case ($urandom_range(5))
      0: return '0;
      1: return cfg_data_t'(BLOCKS);
      2: return home;
      default: return cfg_data_t'($urandom_range(BLOCKS));
    endcase
  endfunction

  // Allocation words carry random junk in the fields that an allocate ignores.
  task automatic alloc_word(class_t c);
    send_word(req_t'{OP_ALLOC, c, 1'($urandom_range(1)), ridx_t'($urandom_range(127))},
              1'b0, '0);
  endtask

  task automatic return_word(int b);
    send_word(req_t'{OP_RETURN, class_t'($urandom_range(3)), 1'b0, ridx_t'(b)}, 1'b0, '0);
  endtask

  // Malformed returns: null block, index past the pool, or a free block (block 0 if none is free).
  task automatic noise_word();
    int b;
    b = pick_block(1'b0);
    case ($urandom_range(2))
      0: send_word(req_t'{OP_RETURN, rand_class(), 1'b1, ridx_t'($urandom_range(127))},
                   1'b0, '0);
      1: send_word(req_t'{OP_RETURN, rand_class(), 1'b0,
                          ridx_t'($urandom_range(127, BLOCKS))}, 1'b0, '0);
      default: return_word(b < 0 ? 0 : b);
    endcase
  endtask

  // Mostly allocations and returns of blocks really held, with some noise.
  task automatic mixed_traffic(int n);
    int b;
    int roll;
    repeat (n) begin
      b = pick_block(1'b1);
      roll = $urandom_range(99);
      if (roll < 55 || b < 0) begin
        alloc_word(rand_class());
      end else if (roll < 90) begin
        return_word(b);
      end else begin
        noise_word();
      end
    end
  endtask

  task automatic release_all();
    int b;
    b = pick_block(1'b1);
    while (b >= 0) begin
      return_word(b);
      b = pick_block(1'b1);
    end
  endtask

  initial begin : stimulus
    class_t c;
    bit     retune;
    // Every input known from time zero; reset held low.
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.opcode = OP_ALLOC;
    in_ch.request_class = CLS_RECEIVE;
    in_ch.no_block = 1'b0;
    in_ch.return_index = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_MAX_OTHER;
    cfg_ch.data = '0;
    word_fixed = 1'b0;
    word_want = '0;

    // Shadow pool after reset: chain 0 -> 1 -> ... with block 0 at the head,
    // registers at their reset values and the credit loaded from the reserve.
    foreach (pool_link[i]) begin
      pool_link[i] = i + 1;
      pool_free[i] = 1'b1;
      pool_owner[i] = CLS_RECEIVE;
    end
    pool_head = 0;
    held_total = 0;
    held_other = 0;
    cap_other = int'(RST_MAX_OTHER);
    credit = int'(RST_DATA_RESERVE);

    words_goal = RANDOM_WORDS;
    foreach (STEPS[i]) if (STEPS[i].kind == ROW_WORD) words_goal++;

    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // Walk the directed table; register rows wait for the block to drain first.
    for (int i = 0; i < N_STEPS; i++) begin
      if (STEPS[i].kind == ROW_CFG) begin
        quiesce();
        cfg_write(STEPS[i].reg_idx, STEPS[i].reg_val);
      end else begin
        send_word(req_t'{STEPS[i].op, STEPS[i].cls, STEPS[i].no_block, STEPS[i].ridx},
                  STEPS[i].fixed,
                  res_t'{STEPS[i].status, STEPS[i].granted, STEPS[i].in_use,
                         STEPS[i].other});
      end
    end

    // Random episodes, each optionally under a fresh pair of register settings.
    retune = 1'b1;
    while (words_sent < words_goal) begin
      if (retune || $urandom_range(2) == 0) begin
        quiesce();
        cfg_write(REG_MAX_OTHER, pick_setting(RST_MAX_OTHER));
        cfg_write(REG_DATA_RESERVE, pick_setting(RST_DATA_RESERVE));
        retune = 1'b0;
      end
      case ($urandom_range(9))
        6: begin
          // Push the pool to empty under whatever caps are set, then hand it all back.
          repeat (BLOCKS + 6) alloc_word(rand_class());
          release_all();
        end
        7: begin
          // Hold every block as data, reload the credit while they are all out, then
          // return them: the credit must stop at its ceiling instead of wrapping, so
          // the data grants that follow still succeed.
          release_all();
          quiesce();
          cfg_write(REG_DATA_RESERVE, cfg_data_t'(BLOCKS));
          repeat (BLOCKS + 2) alloc_word(CLS_DATA);
          quiesce();
          cfg_write(REG_DATA_RESERVE, cfg_data_t'(BLOCKS));
          alloc_word(CLS_DATA);
          alloc_word(CLS_RECEIVE);
          release_all();
          repeat (3) alloc_word(CLS_DATA);
        end
        8: begin
          // Fill the pool without data blocks, grant one credit, and ask for data on
          // the empty pool: the credit must survive for the grant after one return.
          quiesce();
          cfg_write(REG_MAX_OTHER, cfg_data_t'(BLOCKS));
          while (held_total < BLOCKS) begin
            c = rand_class();
            alloc_word(c == CLS_DATA ? CLS_UNASSIGNED : c);
          end
          quiesce();
          cfg_write(REG_DATA_RESERVE, cfg_data_t'(1));
          alloc_word(CLS_DATA);
          return_word(pick_block(1'b1));
          alloc_word(CLS_DATA);
          alloc_word(CLS_DATA);
        end
        9: begin
          // Let the pipeline run dry before a short burst.
          quiesce();
          mixed_traffic($urandom_range(30, 10));
        end
        default: mixed_traffic($urandom_range(60, 20));
      endcase
    end

    quiesce();
    // Let any stray result word show at the output.
    repeat (6) @(posedge clk);

    $display("covered %0d request words, %0d result words checked, %0d register writes",
             words_sent, results_seen, cfg_writes);
    $display("statuses: granted %0d, cap %0d, wait %0d, empty %0d, returned %0d,",
             st_seen[ST_GRANTED], st_seen[ST_CAP], st_seen[ST_WAIT], st_seen[ST_EMPTY],
             st_seen[ST_RETURNED], " null %0d, bad index %0d, already free %0d",
             st_seen[ST_NULL], st_seen[ST_BAD_INDEX], st_seen[ST_ALREADY_FREE]);
    if (faults == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/bpaq_pkg.sv
rtl/core/bpaq_if.sv
rtl/core/bpaq_free_stack.sv
rtl/core/buffer_pool_allocator_with_quota.sv
dv/testbench.sv
